### hw/rtl/cha_pkg.sv
// cha_pkg: types and constants for the convex hull area block.
// No dependencies.
package cha_pkg;

  localparam int MaxPointsDef = 1024;
  localparam int CoordBitsDef = 24;
  localparam int AreaBits     = 58;
  localparam int SizeBits     = 11;

  typedef struct packed {
    logic signed [CoordBitsDef-1:0] px;
    logic signed [CoordBitsDef-1:0] py;
    logic                           last_point;
  } in_t;

  typedef struct packed {
    logic [AreaBits-1:0] area_whole;
    logic                half_unit;
    logic [SizeBits-1:0] hull_size;
    logic                overflowed;
  } out_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SORT_KEY,  // read store[i]
    S_SORT_KLD,  // latch key
    S_SORT_RD,   // read store[j-1]
    S_SORT_CMP,  // compare key with store[j-1], shift up
    S_SORT_PUT,  // place key at j
    S_HL_FETCH,  // read point i
    S_HL_PT,     // latch point
    S_HL_RDA,    // read stack[top-2]
    S_HL_RDB,    // latch a, read stack[top-1]
    S_HL_LDB,    // latch b
    S_HL_MUL,    // two products
    S_HL_CMP,    // pop on a non-left turn
    S_HL_PUSH,   // push point, advance
    S_HL_END,    // drop the repeated start vertex
    S_AR_RDA,
    S_AR_RDB,
    S_AR_LDB,
    S_AR_MUL,
    S_AR_ACC,
    S_DONE
  } state_t;

endpackage

### hw/rtl/convex_hull_area_top.sv
// convex_hull_area_top: convex hull area over a streamed point set.
// Depends on cha_pkg.
//
// Usage:
//   A transaction is taken when start is high and busy is low; its payload
//   (in_data) carries one point and a last_point flag. Points are stored one
//   per cycle while busy is low. The transaction with last_point set starts the computation:
//   insertion sort on x then y, Andrew's monotone chain (lower then upper
//   hull, popping turns with cross product <= 0), then a shoelace sum.
//   busy stays high during that work. The result appears on out_data for one
//   cycle with done high; the receiver cannot stall it.
//   Sorting is O(n^2) in the worst case. The pace of every phase is set
//   by the point and stack memories, each with one read and one write
//   port, and by the shared multiplier pair, used once per step.
//   Points beyond MAX_POINTS are dropped and flag overflowed in the result.
//   Reset clears counts and flags; the memories need no clearing.
module convex_hull_area_top #(
  parameter int MAX_POINTS = cha_pkg::MaxPointsDef
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  cha_pkg::in_t   in_data,
  output logic           busy,
  output logic           done,
  output cha_pkg::out_t  out_data
);

  localparam int CB = cha_pkg::CoordBitsDef;
  localparam int AW = $clog2(MAX_POINTS);        // point address width
  localparam int CW = $clog2(MAX_POINTS + 3);    // counts, stack top, pop floor
  localparam int SW = $clog2(MAX_POINTS + 1);    // stack address (N+1 entries)
  localparam int DW = CB + 2;                    // differences
  localparam int PW = 2 * DW;                    // products
  localparam logic [CW-1:0] NPTS = CW'(MAX_POINTS);
  localparam logic [CW-1:0] NSTK = CW'(MAX_POINTS + 1);

  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
  } pt_t;

  pt_t pstore [MAX_POINTS];
  pt_t hstack [MAX_POINTS+1];

  cha_pkg::state_t state, state_next;

  logic [CW-1:0] count;
  logic [CW-1:0] top;
  logic [CW-1:0] lim;        // pop floor: 2 for lower, t for upper
  logic [CW-1:0] idx_i;
  logic [CW-1:0] idx_j;
  logic          upper;
  logic          ovf;
  pt_t           key, pa, pb, pc, rd_p, rd_h;
  logic signed [PW-1:0] prod_l, prod_r;
  logic [63:0]   accum;

  // memory ports
  logic          p_we, p_re;
  logic [AW-1:0] p_waddr, p_raddr;
  pt_t           p_wdata;
  logic          h_we, h_re;
  logic [SW-1:0] h_waddr, h_raddr;

  always_ff @(posedge clk) begin
    if (p_we) pstore[p_waddr] <= p_wdata;
    if (p_re) rd_p <= pstore[p_raddr];
  end

  always_ff @(posedge clk) begin
    if (h_we) hstack[h_waddr] <= pc;
    if (h_re) rd_h <= hstack[h_raddr];
  end

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state != cha_pkg::S_IDLE);

  // shared multiplier operands
  logic signed [DW-1:0] m0a, m0b, m1a, m1b;
  always_comb begin
    if (state == cha_pkg::S_AR_MUL) begin
      m0a = DW'(pa.x); m0b = DW'(pb.y);
      m1a = DW'(pa.y); m1b = DW'(pb.x);
    end else begin
      m0a = DW'(pb.x) - DW'(pa.x); m0b = DW'(pc.y) - DW'(pa.y);
      m1a = DW'(pb.y) - DW'(pa.y); m1b = DW'(pc.x) - DW'(pa.x);
    end
  end

  logic key_less;
  assign key_less = (key.x < rd_p.x) || ((key.x == rd_p.x) && (key.y < rd_p.y));

  logic pop_turn;
  assign pop_turn = (prod_l <= prod_r);

  logic [CW-1:0] count_inc, top_push, top_dec;
  assign count_inc = (count < NPTS) ? count + 1'b1 : count;
  assign top_push  = (top < NSTK) ? top + 1'b1 : top;
  assign top_dec   = (top != '0) ? top - 1'b1 : top;

  always_comb begin
    state_next = state;
    unique case (state)
      cha_pkg::S_IDLE:
        if (accept && in_data.last_point) begin
          if (count_inc > CW'(1)) state_next = cha_pkg::S_SORT_KEY;
          else state_next = cha_pkg::S_HL_FETCH;
        end
      cha_pkg::S_SORT_KEY: state_next = cha_pkg::S_SORT_KLD;
      cha_pkg::S_SORT_KLD: state_next = cha_pkg::S_SORT_RD;
      cha_pkg::S_SORT_RD:  state_next = cha_pkg::S_SORT_CMP;
      cha_pkg::S_SORT_CMP:
        if (key_less && idx_j != CW'(1)) state_next = cha_pkg::S_SORT_RD;
        else state_next = cha_pkg::S_SORT_PUT;
      cha_pkg::S_SORT_PUT:
        if (idx_i + 1'b1 < count) state_next = cha_pkg::S_SORT_KEY;
        else state_next = cha_pkg::S_HL_FETCH;
      cha_pkg::S_HL_FETCH: state_next = cha_pkg::S_HL_PT;
      cha_pkg::S_HL_PT:
        state_next = (top >= lim) ? cha_pkg::S_HL_RDA : cha_pkg::S_HL_PUSH;
      cha_pkg::S_HL_RDA:   state_next = cha_pkg::S_HL_RDB;
      cha_pkg::S_HL_RDB:   state_next = cha_pkg::S_HL_LDB;
      cha_pkg::S_HL_LDB:   state_next = cha_pkg::S_HL_MUL;
      cha_pkg::S_HL_MUL:   state_next = cha_pkg::S_HL_CMP;
      cha_pkg::S_HL_CMP:
        if (pop_turn && top_dec >= lim) state_next = cha_pkg::S_HL_RDA;
        else state_next = cha_pkg::S_HL_PUSH;
      cha_pkg::S_HL_PUSH:
        if (!upper && idx_i + 1'b1 < count) state_next = cha_pkg::S_HL_FETCH;
        else if (!upper && count > CW'(1)) state_next = cha_pkg::S_HL_FETCH;
        else if (upper && idx_i != '0) state_next = cha_pkg::S_HL_FETCH;
        else state_next = cha_pkg::S_HL_END;
      cha_pkg::S_HL_END:   state_next = cha_pkg::S_AR_RDA;
      cha_pkg::S_AR_RDA:
        state_next = (idx_i >= top) ? cha_pkg::S_DONE : cha_pkg::S_AR_RDB;
      cha_pkg::S_AR_RDB:   state_next = cha_pkg::S_AR_LDB;
      cha_pkg::S_AR_LDB:   state_next = cha_pkg::S_AR_MUL;
      cha_pkg::S_AR_MUL:   state_next = cha_pkg::S_AR_ACC;
      cha_pkg::S_AR_ACC:   state_next = cha_pkg::S_AR_RDA;
      cha_pkg::S_DONE:     state_next = cha_pkg::S_IDLE;
      default:             state_next = cha_pkg::S_IDLE;
    endcase
  end

  // memory addressing
  always_comb begin
    p_we = 1'b0; p_re = 1'b0; p_waddr = '0; p_wdata = key; p_raddr = '0;
    h_we = 1'b0; h_re = 1'b0; h_waddr = '0; h_raddr = '0;
    unique case (state)
      cha_pkg::S_IDLE: begin
        p_we    = accept && (count < NPTS);
        p_waddr = AW'(count);
        p_wdata = '{x: in_data.px, y: in_data.py};
      end
      cha_pkg::S_SORT_KEY: begin
        p_re    = 1'b1;
        p_raddr = AW'(idx_i);
      end
      cha_pkg::S_SORT_RD: begin
        p_re    = 1'b1;
        p_raddr = AW'(idx_j - 1'b1);
      end
      cha_pkg::S_SORT_CMP: begin
        p_we    = key_less;
        p_waddr = AW'(idx_j);
        p_wdata = rd_p;
      end
      cha_pkg::S_SORT_PUT: begin
        p_we    = 1'b1;
        p_waddr = AW'(idx_j);
      end
      cha_pkg::S_HL_FETCH: begin
        p_re    = 1'b1;
        p_raddr = AW'(idx_i);
      end
      cha_pkg::S_HL_RDA: begin
        h_re    = 1'b1;
        h_raddr = SW'(top - CW'(2));
      end
      cha_pkg::S_HL_RDB: begin
        h_re    = 1'b1;
        h_raddr = SW'(top - 1'b1);
      end
      cha_pkg::S_HL_PUSH: begin
        h_we    = (top < NSTK);
        h_waddr = SW'(top);
      end
      cha_pkg::S_AR_RDA: begin
        h_re    = 1'b1;
        h_raddr = SW'(idx_i);
      end
      cha_pkg::S_AR_RDB: begin
        h_re    = 1'b1;
        h_raddr = (idx_i + 1'b1 < top) ? SW'(idx_i + 1'b1) : '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cha_pkg::S_IDLE;
      count <= '0;
      top   <= '0;
      lim   <= CW'(2);
      idx_i <= '0;
      idx_j <= '0;
      ovf   <= 1'b0;
      done  <= 1'b0;
      upper <= 1'b0;
      accum <= '0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      unique case (state)
        cha_pkg::S_IDLE:
          if (accept) begin
            count <= count_inc;
            if (count >= NPTS) ovf <= 1'b1;
            if (in_data.last_point) begin
              top   <= '0;
              upper <= 1'b0;
              lim   <= CW'(2);
              idx_i <= (count_inc > CW'(1)) ? CW'(1) : '0;
            end
          end
        cha_pkg::S_SORT_KLD: begin
          key   <= rd_p;
          idx_j <= idx_i;
        end
        cha_pkg::S_SORT_CMP:
          if (key_less) idx_j <= idx_j - 1'b1;
        cha_pkg::S_SORT_PUT:
          if (idx_i + 1'b1 < count) idx_i <= idx_i + 1'b1;
          else idx_i <= '0;
        cha_pkg::S_HL_PT:  pc <= rd_p;
        cha_pkg::S_HL_RDB: pa <= rd_h;
        cha_pkg::S_HL_LDB: pb <= rd_h;
        cha_pkg::S_HL_MUL: begin
          prod_l <= PW'(m0a * m0b);
          prod_r <= PW'(m1a * m1b);
        end
        cha_pkg::S_HL_CMP:
          if (pop_turn) top <= top_dec;
        cha_pkg::S_HL_PUSH: begin
          top <= top_push;
          if (!upper) begin
            if (idx_i + 1'b1 < count) begin
              idx_i <= idx_i + 1'b1;
            end else begin
              // upper walk runs from point n-2 down to 0
              upper <= 1'b1;
              lim   <= top_push + 1'b1;
              idx_i <= count - CW'(2);
            end
          end else if (idx_i != '0) begin
            idx_i <= idx_i - 1'b1;
          end
        end
        cha_pkg::S_HL_END: begin
          top   <= top_dec;
          idx_i <= '0;
          accum <= '0;
        end
        cha_pkg::S_AR_RDB: pa <= rd_h;
        cha_pkg::S_AR_LDB: pb <= rd_h;
        cha_pkg::S_AR_MUL: begin
          prod_l <= PW'(m0a * m0b);
          prod_r <= PW'(m1a * m1b);
        end
        cha_pkg::S_AR_ACC: begin
          accum <= accum + 64'(prod_l) - 64'(prod_r);
          idx_i <= idx_i + 1'b1;
        end
        cha_pkg::S_DONE: begin
          done  <= 1'b1;
          count <= '0;
          ovf   <= 1'b0;
          top   <= '0;
          upper <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  logic [63:0] mag;
  assign mag = accum[63] ? (64'd0 - accum) : accum;

  always_ff @(posedge clk) begin
    if (state == cha_pkg::S_DONE) begin
      out_data.area_whole <= mag[cha_pkg::AreaBits:1];
      out_data.half_unit  <= mag[0];
      out_data.hull_size  <= cha_pkg::SizeBits'(top);
      out_data.overflowed <= ovf;
    end
  end

endmodule

### dv/tb_convex_hull_area_top.sv
// tb_convex_hull_area_top: self-checking testbench for convex_hull_area_top.
// Depends on cha_pkg and the convex_hull_area_top RTL.
// Directed table of point sets, then random sets with a model-based checker.
`timescale 1ns / 100ps

module tb_convex_hull_area_top;

  // Widest coordinates, as signed values
  localparam longint CMin = -(longint'(1) <<< (cha_pkg::CoordBitsDef - 1));
  localparam longint CMax = (longint'(1) <<< (cha_pkg::CoordBitsDef - 1)) - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  cha_pkg::in_t  in_data = '0;
  logic busy;
  logic done;
  cha_pkg::out_t out_data;

  always #10 clk = ~clk;

  convex_hull_area_top u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .in_data  (in_data),
    .busy     (busy),
    .done     (done),
    .out_data (out_data)
  );

  typedef struct {
    longint x;
    longint y;
  } pt_s;

  // One row of the directed table; typed rows carry a hand-derived result
  typedef struct {
    cha_pkg::in_t  pt;
    bit            typed;
    cha_pkg::out_t res;
  } row_s;

  pt_s  set_pts[$];     // points of the set now loading, as the block stores them
  bit   set_over;       // a point of this set was dropped
  cha_pkg::out_t area_due[$];    // results still owed by the block
  row_s table_rows[$];
  int   fail_cnt  = 0;
  int   sets_done = 0;
  int   pts_sent  = 0;
  int   burst_left = 0;

  // Cross product of a->b->c is zero or negative: the turn gets popped
  function automatic bit flat_or_cw(pt_s a, pt_s b, pt_s c);
    longint l, r;
    l = (b.x - a.x) * (c.y - a.y);
    r = (b.y - a.y) * (c.x - a.x);
    return l <= r;
  endfunction

  // Sort, monotone chain, shoelace: the result a finished set should give
  function automatic cha_pkg::out_t hull_area_of(pt_s pts[$], bit over);
    pt_s p[$];
    pt_s stk[cha_pkg::MaxPointsDef+1];
    pt_s key;
    int n, i, j, top, t;
    longint unsigned acc, mag;
    cha_pkg::out_t r;
    p = pts;
    n = p.size();
    for (i = 1; i < n; i++) begin
      key = p[i];
      j = i;
      while (j > 0 && (key.x < p[j-1].x || (key.x == p[j-1].x && key.y < p[j-1].y))) begin
        p[j] = p[j-1];
        j--;
      end
      p[j] = key;
    end
    top = 0;
    // lower hull
    for (i = 0; i < n; i++) begin
      while (top >= 2 && flat_or_cw(stk[top-2], stk[top-1], p[i])) top--;
      if (top < cha_pkg::MaxPointsDef + 1) begin
        stk[top] = p[i];
        top++;
      end
    end
    // upper hull
    t = top + 1;
    for (i = n; i > 1; i--) begin
      while (top >= t && flat_or_cw(stk[top-2], stk[top-1], p[i-2])) top--;
      if (top < cha_pkg::MaxPointsDef + 1) begin
        stk[top] = p[i-2];
        top++;
      end
    end
    if (top > 0) top--;
    acc = 0;
    for (i = 0; i < top; i++) begin
      j = (i + 1 < top) ? i + 1 : 0;
      acc += longint'(stk[i].x * stk[j].y) - longint'(stk[i].y * stk[j].x);
    end
    mag = acc[63] ? (64'd0 - acc) : acc;
    r.area_whole = mag[cha_pkg::AreaBits:1];
    r.half_unit  = mag[0];
    r.hull_size  = top[cha_pkg::SizeBits-1:0];
    r.overflowed = over;
    return r;
  endfunction

  // Mirror of what the block does with one accepted transaction
  task automatic note_point(cha_pkg::in_t it, bit typed, cha_pkg::out_t res);
    pt_s q;
    cha_pkg::out_t r;
    q.x = longint'(it.px);
    q.y = longint'(it.py);
    if (set_pts.size() < cha_pkg::MaxPointsDef) set_pts.insert(set_pts.size(), q);
    else set_over = 1'b1;
    if (it.last_point) begin
      r = hull_area_of(set_pts, set_over);
      area_due.insert(area_due.size(), typed ? res : r);
      set_pts.delete();
      set_over = 1'b0;
      sets_done++;
    end
    pts_sent++;
  endtask

  // Drive one transaction; called at a falling edge, returns at a falling edge.
  // The sender runs in bursts; between bursts start drops for a random gap.
  task automatic send_point(cha_pkg::in_t it, bit typed = 1'b0, cha_pkg::out_t res = '0);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    note_point(it, typed, res);
    @(negedge clk);
    burst_left--;
  endtask

  // Hold off the sender until every owed result is back
  task automatic drain();
    start <= 1'b0;
    while (area_due.size() != 0) @(posedge clk);
    @(negedge clk);
    burst_left = 0;
  endtask

  function automatic cha_pkg::in_t mk_pt(longint x, longint y, bit last);
    cha_pkg::in_t it;
    it.px = x[cha_pkg::CoordBitsDef-1:0];
    it.py = y[cha_pkg::CoordBitsDef-1:0];
    it.last_point = last;
    return it;
  endfunction

  function automatic longint rand_coord(int span);
    if (span == 0)
      return longint'($signed($urandom_range(0, (1 << cha_pkg::CoordBitsDef) - 1)) <<< 8) >>> 8;
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  // One set of n random points; span 0 means the full coordinate range
  task automatic send_set(int n, int span);
    for (int k = 0; k < n; k++)
      send_point(mk_pt(rand_coord(span), rand_coord(span), k == n - 1));
  endtask

  task automatic add_row(longint x, longint y, bit last, bit typed = 1'b0,
                         longint unsigned whole = 0, bit half = 0, int hsz = 0);
    row_s r;
    r.pt = mk_pt(x, y, last);
    r.typed = typed;
    r.res.area_whole = whole[cha_pkg::AreaBits-1:0];
    r.res.half_unit  = half;
    r.res.hull_size  = hsz[cha_pkg::SizeBits-1:0];
    r.res.overflowed = 1'b0;
    table_rows.insert(table_rows.size(), r);
  endtask

  // Result checker: done marks a one-cycle result, which cannot be stalled
  always @(posedge clk) begin
    if (!rst && done) begin
      if (area_due.size() == 0) begin
        $error("result with nothing expected: %p", out_data);
        fail_cnt++;
      end else begin
        if (out_data.area_whole !== area_due[0].area_whole) begin
          $error("area_whole: expected %0d, got %0d", area_due[0].area_whole,
                 out_data.area_whole);
          fail_cnt++;
        end
        if (out_data.half_unit !== area_due[0].half_unit) begin
          $error("half_unit: expected %0d, got %0d", area_due[0].half_unit,
                 out_data.half_unit);
          fail_cnt++;
        end
        if (out_data.hull_size !== area_due[0].hull_size) begin
          $error("hull_size: expected %0d, got %0d", area_due[0].hull_size,
                 out_data.hull_size);
          fail_cnt++;
        end
        if (out_data.overflowed !== area_due[0].overflowed) begin
          $error("overflowed: expected %0d, got %0d", area_due[0].overflowed,
                 out_data.overflowed);
          fail_cnt++;
        end
        void'(area_due.pop_front());
      end
    end
  end

  initial begin
    int n, sel;
    set_over = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Lone point: no hull at all
    add_row(5, 5, 1, 1, 0, 0, 0);
    // Extreme right triangle: twice the area is (2^24-1)^2, which is odd
    add_row(CMin, CMin, 0);
    add_row(CMax, CMin, 0);
    add_row(CMin, CMax, 1, 1, 64'd140737471578112, 1, 3);
    // Collinear triple collapses to two vertices, area zero
    add_row(0, 0, 0);
    add_row(1, 1, 0);
    add_row(2, 2, 1, 1, 0, 0, 2);
    // Full-range square plus an inner point
    add_row(CMax, CMax, 0);
    add_row(CMin, CMin, 0);
    add_row(0, 0, 0);
    add_row(CMax, CMin, 0);
    add_row(CMin, CMax, 1);
    // Repeated point
    add_row(7, -7, 0);
    add_row(7, -7, 0);
    add_row(7, -7, 1);
    // Two points, then a small counterclockwise-ordered quad with a duplicate x
    add_row(-1, 3, 0);
    add_row(4, -2, 1);
    add_row(3, 0, 0);
    add_row(3, 5, 0);
    add_row(-2, 5, 0);
    add_row(-2, 0, 0);
    add_row(3, 0, 1);
    @(negedge clk);
    foreach (table_rows[k]) send_point(table_rows[k].pt, table_rows[k].typed, table_rows[k].res);
    drain();

    // Random sets, mostly small; a few dense grids for collinear and repeated points
    while (pts_sent < 800) begin
      sel = $urandom_range(0, 9);
      n = (sel == 0) ? $urandom_range(1, 2) : (sel < 8) ? $urandom_range(3, 12)
                                                        : $urandom_range(13, 24);
      send_set(n, ($urandom_range(0, 3) == 0) ? 2 : ($urandom_range(0, 2) == 0) ? 8 : 0);
      if ($urandom_range(0, 15) == 0) drain();
    end

    // Store filled past capacity, pre-sorted by x to keep the sort short;
    // the last point is itself dropped but still closes the set
    drain();
    for (int k = 0; k < cha_pkg::MaxPointsDef + 2; k++)
      send_point(mk_pt(CMin + k * 8191, rand_coord(0), k == cha_pkg::MaxPointsDef + 1));
    drain();

    while (pts_sent < 1850) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(3, 16);
      send_set(n, ($urandom_range(0, 3) == 0) ? 3 : 0);
    end

    start <= 1'b0;
    while (area_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Covered %0d point transactions in %0d sets, including one overflowed set.",
             pts_sent, sets_done);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog, well above the slowest legal run
  initial begin
    #100_000_000;
    $display("Timeout with %0d results outstanding", area_due.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/cha_pkg.sv
hw/rtl/convex_hull_area_top.sv
dv/tb_convex_hull_area_top.sv
